// ===== rtl/rrc_pkg.sv =====
package rrc_pkg;

  localparam int unsigned DefRingDepth      = 64;
  localparam int unsigned DefMaxPacketBytes = 1500;
  localparam int unsigned QueueDepth        = 2;

  localparam int unsigned SeqW     = 16;
  localparam int unsigned LenW     = 11;
  localparam int unsigned GenW     = 8;
  localparam int unsigned SlotIdxW = 6;
  localparam int unsigned HeadW    = 32;

  typedef enum logic [1:0] {
    K_PUSH   = 2'd0,
    K_LOOKUP = 2'd1,
    K_RETX   = 2'd2,
    K_REPLAY = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_MISS   = 3'd1,
    ST_DONE   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_BADLEN = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_BADLEN = 3'd1,
    CMD_LOOKUP = 3'd2,
    CMD_RETX   = 3'd3,
    CMD_REPLAY = 3'd4
  } cmd_e;

  typedef struct packed {
    kind_e             kind;
    logic [SeqW-1:0]   packet_seq;
    logic [LenW-1:0]   packet_length;
    logic              group_start;
    logic [GenW-1:0]   nack_generation;
  } rrc_req_t;

  typedef struct packed {
    status_e             status;
    logic [SlotIdxW-1:0] slot_index;
    logic [LenW-1:0]     out_length;
    logic                out_group_start;
    logic                last;
  } rrc_rsp_t;

  typedef struct packed {
    cmd_e            op;
    logic [SeqW-1:0] seq;
    logic [LenW-1:0] len;
    logic            flag;
    logic [GenW-1:0] gen;
  } rrc_cmd_t;

  typedef struct packed {
    logic [SeqW-1:0] seq;
    logic [LenW-1:0] len;
    logic            flag;
    logic [GenW-1:0] gen;
  } rrc_slot_t;

endpackage

// ===== rtl/rrc_ram.sv =====
module rrc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/rrc_front.sv =====
module rrc_front #(
  parameter int unsigned MaxPacketBytes = 1500
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  rrc_pkg::rrc_req_t req_i,
  output logic              cq_valid_o,
  output rrc_pkg::rrc_cmd_t cq_o,
  input  logic              cq_pop_i
);
  import rrc_pkg::*;

  localparam int unsigned QPtrW = $clog2(QueueDepth);
  localparam int unsigned QCntW = $clog2(QueueDepth + 1);

  rrc_cmd_t               mem_q [QueueDepth];
  rrc_cmd_t               cmd;
  logic [QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]       cnt_q, cnt_d;
  logic                   wr_en;

  // classify the request
  always_comb begin
    cmd.seq  = req_i.packet_seq;
    cmd.len  = req_i.packet_length;
    cmd.flag = req_i.group_start;
    cmd.gen  = req_i.nack_generation;
    case (req_i.kind)
      K_PUSH: begin
        if (req_i.packet_length == '0 ||
            req_i.packet_length > LenW'(MaxPacketBytes)) begin
          cmd.op = CMD_BADLEN;
        end else begin
          cmd.op = CMD_PUSH;
        end
      end
      K_LOOKUP: cmd.op = CMD_LOOKUP;
      K_RETX:   cmd.op = CMD_RETX;
      K_REPLAY: cmd.op = CMD_REPLAY;
      default:  cmd.op = CMD_REPLAY;
    endcase
  end

  assign full_o     = (cnt_q == QCntW'(QueueDepth));
  assign wr_en      = push_i && !full_o;
  assign cq_valid_o = (cnt_q != '0);
  assign cq_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !(cq_pop_i && cq_valid_o)) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!wr_en && cq_pop_i && cq_valid_o) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (cq_pop_i && cq_valid_o) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cmd;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QueueDepth))
    else $error("command queue overfilled");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cq_pop_i |-> cq_valid_o)
    else $error("command queue popped while empty");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !cq_pop_i) |=> full_o)
    else $error("queue drained without a pop");

endmodule

// ===== rtl/rrc_back.sv =====
module rrc_back #(
  parameter int unsigned RingDepth = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cq_valid_i,
  input  rrc_pkg::rrc_cmd_t cq_i,
  output logic              cq_pop_o,
  output logic              rsp_valid_o,
  output rrc_pkg::rrc_rsp_t rsp_o,
  input  logic              pop_i
);
  import rrc_pkg::*;

  localparam int unsigned SlotW = $clog2(RingDepth);
  localparam int unsigned CntW  = $clog2(RingDepth + 1);
  localparam int unsigned SlotBits = $bits(rrc_slot_t);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_OLD  = 4'b0010,
    S_TGT  = 4'b0100,
    S_RPL  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [HeadW-1:0]  head_q, head_d;
  logic [HeadW-1:0]  start_q, start_d;
  logic [HeadW-1:0]  gsp_q, gsp_d;
  logic [HeadW-1:0]  ptr_q, ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [SlotW-1:0]  idx_q, idx_d;
  logic [HeadW-1:0]  rpl_start;
  logic [HeadW-1:0]  ptr_inc;
  logic [SeqW-1:0]   seq_dist;
  logic [SlotW-1:0]  tgt;
  logic              out_free;
  logic              emit;
  rrc_rsp_t          emit_rsp;
  rrc_rsp_t          rsp_q;
  logic              rsp_valid_q;
  logic              ram_we, ram_re;
  logic [SlotW-1:0]  ram_waddr, ram_raddr;
  rrc_slot_t         ram_wdata, ram_rdata;
  logic [SlotBits-1:0] ram_rbits;

  rrc_ram #(
    .Width(SlotBits),
    .Depth(RingDepth)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rbits)
  );

  assign ram_rdata = rrc_slot_t'(ram_rbits);

  assign out_free  = !rsp_valid_q || pop_i;
  assign rpl_start = (gsp_q > start_q) ? gsp_q : start_q;
  assign ptr_inc   = ptr_q + HeadW'(1);
  assign seq_dist  = cq_i.seq - ram_rdata.seq;
  assign tgt       = start_q[SlotW-1:0] + seq_dist[SlotW-1:0];

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    start_d   = start_q;
    gsp_d     = gsp_q;
    ptr_d     = ptr_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    ram_we    = 1'b0;
    ram_waddr = head_q[SlotW-1:0];
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = start_q[SlotW-1:0];
    cq_pop_o  = 1'b0;
    emit      = 1'b0;
    emit_rsp  = '0;
    emit_rsp.last = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (cq_valid_i) begin
          case (cq_i.op)
            CMD_BADLEN: begin
              if (out_free) begin
                emit            = 1'b1;
                emit_rsp.status = ST_BADLEN;
                cq_pop_o        = 1'b1;
              end
            end
            CMD_PUSH: begin
              if (out_free) begin
                ram_we         = 1'b1;
                ram_wdata.seq  = cq_i.seq;
                ram_wdata.len  = cq_i.len;
                ram_wdata.flag = cq_i.flag;
                ram_wdata.gen  = '0;
                if (cq_i.flag) begin
                  gsp_d = head_q;
                end
                head_d = head_q + HeadW'(1);
                if (cnt_q == CntW'(RingDepth)) begin
                  start_d = start_q + HeadW'(1);
                end else begin
                  cnt_d = cnt_q + CntW'(1);
                end
                emit                     = 1'b1;
                emit_rsp.status          = ST_OK;
                emit_rsp.slot_index      = SlotIdxW'(head_q[SlotW-1:0]);
                emit_rsp.out_length      = cq_i.len;
                emit_rsp.out_group_start = cq_i.flag;
                cq_pop_o                 = 1'b1;
              end
            end
            CMD_LOOKUP, CMD_RETX: begin
              if (cnt_q == '0) begin
                if (out_free) begin
                  emit            = 1'b1;
                  emit_rsp.status = ST_EMPTY;
                  cq_pop_o        = 1'b1;
                end
              end else begin
                ram_re    = 1'b1;
                ram_raddr = start_q[SlotW-1:0];
                state_d   = S_OLD;
              end
            end
            CMD_REPLAY: begin
              if (cnt_q == '0 || !(rpl_start < head_q)) begin
                if (out_free) begin
                  emit            = 1'b1;
                  emit_rsp.status = ST_EMPTY;
                  cq_pop_o        = 1'b1;
                end
              end else begin
                ptr_d     = rpl_start;
                ram_re    = 1'b1;
                ram_raddr = rpl_start[SlotW-1:0];
                state_d   = S_RPL;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_OLD: begin
        if (seq_dist >= SeqW'(cnt_q)) begin
          if (out_free) begin
            emit            = 1'b1;
            emit_rsp.status = ST_MISS;
            cq_pop_o        = 1'b1;
            state_d         = S_IDLE;
          end
        end else begin
          idx_d     = tgt;
          ram_re    = 1'b1;
          ram_raddr = tgt;
          state_d   = S_TGT;
        end
      end
      S_TGT: begin
        if (out_free) begin
          emit     = 1'b1;
          cq_pop_o = 1'b1;
          state_d  = S_IDLE;
          if (ram_rdata.seq != cq_i.seq) begin
            emit_rsp.status = ST_MISS;
          end else begin
            emit_rsp.slot_index      = SlotIdxW'(idx_q);
            emit_rsp.out_length      = ram_rdata.len;
            emit_rsp.out_group_start = ram_rdata.flag;
            if (cq_i.op == CMD_RETX && ram_rdata.gen == cq_i.gen) begin
              emit_rsp.status = ST_DONE;
            end else begin
              emit_rsp.status = ST_OK;
              if (cq_i.op == CMD_RETX) begin
                ram_we        = 1'b1;
                ram_waddr     = idx_q;
                ram_wdata     = ram_rdata;
                ram_wdata.gen = cq_i.gen;
              end
            end
          end
        end
      end
      S_RPL: begin
        if (out_free) begin
          emit                     = 1'b1;
          emit_rsp.status          = ST_OK;
          emit_rsp.slot_index      = SlotIdxW'(ptr_q[SlotW-1:0]);
          emit_rsp.out_length      = ram_rdata.len;
          emit_rsp.out_group_start = ram_rdata.flag;
          emit_rsp.last            = (ptr_inc == head_q);
          if (ptr_inc == head_q) begin
            cq_pop_o = 1'b1;
            state_d  = S_IDLE;
          end else begin
            ptr_d     = ptr_inc;
            ram_re    = 1'b1;
            ram_raddr = ptr_inc[SlotW-1:0];
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      start_q     <= '0;
      gsp_q       <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      start_q <= start_d;
      gsp_q   <= gsp_d;
      cnt_q   <= cnt_d;
      if (emit) begin
        rsp_valid_q <= 1'b1;
      end else if (pop_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    idx_q <= idx_d;
    if (emit) begin
      rsp_q <= emit_rsp;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(RingDepth))
    else $error("ring count above depth");

  a_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q - start_q) == HeadW'(cnt_q))
    else $error("window start out of step with head and count");

  a_rpl_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RPL) |-> (ptr_q < head_q))
    else $error("replay pointer passed the head");

  a_pop_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cq_pop_o |-> (emit && out_free))
    else $error("command retired without a result slot");

  a_no_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !ram_we || (state_q == S_TGT))
    else $error("slot write outside push or retransmit");

endmodule

// ===== rtl/rtp_retransmit_ring_cache.sv =====
// RTP retransmit ring cache: keeps sequence number, length, picture-group
// flag and retransmit generation for each slot of a ring of cached packets.
// Payload bytes live elsewhere, addressed by the slot index returned here.
//
// Request side is a queue write port: a request is taken when push is high
// and full is low; a two-entry command queue decouples it from execution.
// Result side is a queue read port: the oldest result is on rsp_o while empty
// is low and leaves when pop is high. Results appear in request order, and
// the last flag marks the final result of each request.
//
// Requests run on the slot memory, which has a registered read. Push, bad
// length and an empty ring are answered without a slot read; lookup and
// retransmit read the oldest slot, then the target slot, and skip the target
// read when the sequence number is outside the window; replay starts at the
// group start or window start and reads one slot per result.
//
// Reset empties the ring and both queues; slot contents are not cleared.
// While pop is low the held result stays and execution stalls at its next
// result; requests keep being taken until the command queue is full.
module rtp_retransmit_ring_cache #(
  parameter int unsigned RING_DEPTH       = rrc_pkg::DefRingDepth,
  parameter int unsigned MAX_PACKET_BYTES = rrc_pkg::DefMaxPacketBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  rrc_pkg::rrc_req_t req_i,
  output logic              empty,
  input  logic              pop,
  output rrc_pkg::rrc_rsp_t rsp_o
);
  import rrc_pkg::*;

  rrc_cmd_t cq;
  logic     cq_valid;
  logic     cq_pop;
  logic     rsp_valid;

  rrc_front #(
    .MaxPacketBytes(MAX_PACKET_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .req_i     (req_i),
    .cq_valid_o(cq_valid),
    .cq_o      (cq),
    .cq_pop_i  (cq_pop)
  );

  rrc_back #(
    .RingDepth(RING_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cq_valid_i (cq_valid),
    .cq_i       (cq),
    .cq_pop_o   (cq_pop),
    .rsp_valid_o(rsp_valid),
    .rsp_o      (rsp_o),
    .pop_i      (pop && rsp_valid)
  );

  assign empty = !rsp_valid;

endmodule
